>>> src/losb_pkg.sv
// ----------------------------------------------------------------------------
// losb_pkg
// Shared types, constants and helper functions of the obstacle box block.
// ----------------------------------------------------------------------------
package losb_pkg;

    // configuration register indexes
    localparam logic [3:0] CFG_WIN_LO   = 4'd0;
    localparam logic [3:0] CFG_WIN_HI   = 4'd1;
    localparam logic [3:0] CFG_BAND_LO  = 4'd2;
    localparam logic [3:0] CFG_BAND_HI  = 4'd3;
    localparam logic [3:0] CFG_SAFE     = 4'd4;
    localparam logic [3:0] CFG_MIN_PTS  = 4'd5;
    localparam logic [3:0] CFG_DROP     = 4'd6;
    localparam logic [3:0] CFG_MIN_SIZE = 4'd7;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FEW      = 2'd1;
    localparam logic [1:0] ST_DROP_BIG = 2'd2;

    // CORDIC datapath
    localparam int          CORDIC_STEPS = 16;
    localparam logic [14:0] CORDIC_GAIN  = 15'd19898;
    localparam int          XW           = 38;
    localparam int          ZW           = 34;
    localparam int          NEAR_LIMIT   = 41;

    localparam logic signed [19:0] LEN_MAX = 20'sh7FFFF;
    localparam logic signed [19:0] LEN_MIN = -20'sh80000;

    typedef struct packed {
        logic signed [15:0] win_lo;
        logic signed [15:0] win_hi;
        logic signed [19:0] band_lo;
        logic signed [19:0] band_hi;
        logic [18:0]        safe;
        logic [10:0]        min_pts;
        logic [9:0]         drop;
        logic [18:0]        min_size;
    } t_cfg;

    // one entry handed from front to back
    typedef struct packed {
        logic               crit;
        logic               last;
        logic signed [19:0] x;
        logic signed [19:0] y;
    } t_pt;

    // arctangent table, 2^32 units per turn
    function automatic logic [31:0] atan_tab(input logic [3:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0:  v = 32'd536870912;
            4'd1:  v = 32'd316933406;
            4'd2:  v = 32'd167458907;
            4'd3:  v = 32'd85004756;
            4'd4:  v = 32'd42667331;
            4'd5:  v = 32'd21354465;
            4'd6:  v = 32'd10679840;
            4'd7:  v = 32'd5340245;
            4'd8:  v = 32'd2670163;
            4'd9:  v = 32'd1335087;
            4'd10: v = 32'd667544;
            4'd11: v = 32'd333772;
            4'd12: v = 32'd166886;
            4'd13: v = 32'd83443;
            4'd14: v = 32'd41722;
            default: v = 32'd20861;
        endcase
        return v;
    endfunction

    // saturate to 20-bit signed
    function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
        logic signed [19:0] r;
        if (v > 24'sd524287) begin
            r = LEN_MAX;
        end else if (v < -24'sd524288) begin
            r = LEN_MIN;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage

>>> src/laser_scan_obstacle_box.sv
// ----------------------------------------------------------------------------
// laser_scan_obstacle_box
// Nearest-obstacle box finder for one laser scan, one range sample per item.
// ----------------------------------------------------------------------------
// Usage:
//  s_* carries samples; s_tlast marks the last sample of a scan. m_* gives one
//  result per scan, issued after the last sample. i_cfg_* writes registers
//  0..7 (window, band, safe distance, min points, drop count, min size);
//  write only while idle.
//  Front: an in-window or last sample goes through multiply, 16 CORDIC
//  steps of a single shared rotator, round and hand-off before the next
//  sample is taken; other samples are dropped on entry. A two-entry queue
//  feeds the back, which stores one point per cycle while it is idle.
//  Scan end: if the point and drop checks pass, with n stored points and
//  drop count d the back walks the point memory d+2 times through its single
//  read port, then sizes the box and issues the result.
//  The result waits in the output register while m_tready is low; the front
//  keeps taking samples until the queue fills.
//  Reset: registers return to defaults, point count and overflow flag clear.
// ----------------------------------------------------------------------------
module laser_scan_obstacle_box #(
    parameter int MAX_POINTS = 1024,
    parameter int X_BIAS     = -41
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // range_sample[18:0], beam_angle[34:19]
    input  logic         s_tlast,   // last_sample
    output logic         m_tvalid,
    input  logic         m_tready,
    // near_x[19:0], far_x[39:20], low_y[59:40], high_y[79:60]
    output logic [79:0]  m_tdata,
    output logic [2:0]   m_tuser,   // status[1:0], overflow[2]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [3:0]   i_cfg_index,
    input  logic [19:0]  i_cfg_data
);

    losb_pkg::t_cfg      r_cfg;
    logic                f_valid;
    logic                f_ready;
    losb_pkg::t_pt       f_pt;
    logic                q_valid;
    logic                q_ready;
    losb_pkg::t_pt       q_pt;
    logic [1:0]          status;
    logic signed [19:0]  near_x;
    logic signed [19:0]  far_x;
    logic signed [19:0]  low_y;
    logic signed [19:0]  high_y;
    logic                overflow;

    assign o_cfg_ready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_lo   <= -16'sd13559;
            r_cfg.win_hi   <= 16'sd13559;
            r_cfg.band_lo  <= -20'sd1024;
            r_cfg.band_hi  <= 20'sd1024;
            r_cfg.safe     <= 19'd1638;
            r_cfg.min_pts  <= 11'd15;
            r_cfg.drop     <= 10'd5;
            r_cfg.min_size <= 19'd1229;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                losb_pkg::CFG_WIN_LO:   r_cfg.win_lo   <= i_cfg_data[15:0];
                losb_pkg::CFG_WIN_HI:   r_cfg.win_hi   <= i_cfg_data[15:0];
                losb_pkg::CFG_BAND_LO:  r_cfg.band_lo  <= i_cfg_data;
                losb_pkg::CFG_BAND_HI:  r_cfg.band_hi  <= i_cfg_data;
                losb_pkg::CFG_SAFE:     r_cfg.safe     <= i_cfg_data[18:0];
                losb_pkg::CFG_MIN_PTS:  r_cfg.min_pts  <= i_cfg_data[10:0];
                losb_pkg::CFG_DROP:     r_cfg.drop     <= i_cfg_data[9:0];
                losb_pkg::CFG_MIN_SIZE: r_cfg.min_size <= i_cfg_data[18:0];
                default: ;
            endcase
        end
    end

    losb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_range (s_tdata[18:0]),
        .i_angle (s_tdata[34:19]),
        .i_last  (s_tlast),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_pt    (f_pt)
    );

    losb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_pt    (f_pt),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_pt    (q_pt)
    );

    losb_back #(
        .MAX_POINTS (MAX_POINTS),
        .X_BIAS     (X_BIAS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (q_valid),
        .o_ready    (q_ready),
        .i_pt       (q_pt),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_status   (status),
        .o_near_x   (near_x),
        .o_far_x    (far_x),
        .o_low_y    (low_y),
        .o_high_y   (high_y),
        .o_overflow (overflow)
    );

    assign m_tdata = {high_y, low_y, far_x, near_x};
    assign m_tuser = {overflow, status};

endmodule

>>> src/losb_front.sv
// ----------------------------------------------------------------------------
// losb_front
// Accepts samples, applies the angle window, converts range and angle to x,y
// with an iterative CORDIC and classifies the point against the band and safe distance.
// ----------------------------------------------------------------------------
module losb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  losb_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [18:0]          i_range,
    input  logic signed [15:0]   i_angle,
    input  logic                 i_last,
    output logic                 o_valid,
    input  logic                 i_ready,
    output losb_pkg::t_pt        o_pt
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ITER, S_DONE, S_PUSH} t_state;

    t_state                          r_state;
    logic [18:0]                     r_range;
    logic                            r_flip;
    logic                            r_keep;
    logic                            r_last;
    logic                            r_push;
    logic [3:0]                      r_i;
    logic signed [losb_pkg::XW-1:0]  r_x;
    logic signed [losb_pkg::XW-1:0]  r_y;
    logic signed [losb_pkg::ZW-1:0]  r_z;
    losb_pkg::t_pt                   r_pt;

    logic                            in_win;
    logic signed [16:0]              ang_f;
    logic                            flip;
    logic signed [losb_pkg::XW-1:0]  dx;
    logic signed [losb_pkg::XW-1:0]  dy;
    logic signed [losb_pkg::ZW-1:0]  atan_z;
    logic signed [23:0]              xr;
    logic signed [23:0]              yr;
    logic signed [19:0]              xs;
    logic signed [19:0]              ys;
    logic                            near0;
    logic                            crit;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_PUSH) && r_push;
    assign o_pt    = r_pt;

    // window test and angle fold into a quarter turn
    always_comb begin
        in_win = (i_angle >= i_cfg.win_lo) && (i_angle <= i_cfg.win_hi);
        flip   = 1'b0;
        ang_f  = 17'(i_angle);
        if (i_angle > 16'sd16384) begin
            ang_f = 17'(i_angle) - 17'sd32768;
            flip  = 1'b1;
        end else if (i_angle < -16'sd16384) begin
            ang_f = 17'(i_angle) + 17'sd32768;
            flip  = 1'b1;
        end
    end

    // one rotation step
    always_comb begin
        dx     = r_x >>> r_i;
        dy     = r_y >>> r_i;
        atan_z = losb_pkg::ZW'(losb_pkg::atan_tab(r_i));
    end

    // round, undo fold, saturate and classify
    always_comb begin
        xr = 24'((r_x + losb_pkg::XW'(16384)) >>> 15);
        yr = 24'((r_y + losb_pkg::XW'(16384)) >>> 15);
        if (r_flip) begin
            xr = -xr;
            yr = -yr;
        end
        xs    = losb_pkg::sat20(xr);
        ys    = losb_pkg::sat20(yr);
        near0 = (xs < 20'(losb_pkg::NEAR_LIMIT)) && (xs > -20'(losb_pkg::NEAR_LIMIT)) &&
                (ys < 20'(losb_pkg::NEAR_LIMIT)) && (ys > -20'(losb_pkg::NEAR_LIMIT));
        crit  = r_keep && !near0 && (ys >= i_cfg.band_lo) && (ys <= i_cfg.band_hi) &&
                ($signed(21'(xs)) < $signed({2'b00, i_cfg.safe}));
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_push  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_range <= i_range;
                        r_flip  <= flip;
                        r_keep  <= in_win;
                        r_last  <= i_last;
                        r_z     <= losb_pkg::ZW'(ang_f) <<< 16;
                        if (in_win || i_last) begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_x     <= losb_pkg::XW'(r_range) * losb_pkg::XW'(losb_pkg::CORDIC_GAIN);
                    r_y     <= '0;
                    r_i     <= '0;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - dy;
                        r_y <= r_y + dx;
                        r_z <= r_z - atan_z;
                    end else begin
                        r_x <= r_x + dy;
                        r_y <= r_y - dx;
                        r_z <= r_z + atan_z;
                    end
                    r_i <= r_i + 4'd1;
                    if (r_i == 4'(losb_pkg::CORDIC_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_pt.crit <= crit;
                    r_pt.last <= r_last;
                    r_pt.x    <= xs;
                    r_pt.y    <= ys;
                    r_push    <= crit || r_last;
                    r_state   <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_push || i_ready) begin
                        r_push  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> src/losb_queue.sv
// ----------------------------------------------------------------------------
// losb_queue
// Two-entry queue of classified points between front and back.
// ----------------------------------------------------------------------------
module losb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  losb_pkg::t_pt  i_pt,
    output logic           o_valid,
    input  logic           i_ready,
    output losb_pkg::t_pt  o_pt
);

    losb_pkg::t_pt r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_pt    = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // store entry
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_pt;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> src/losb_back.sv
// ----------------------------------------------------------------------------
// losb_back
// Stores critical points and, at scan end, finds the drop threshold by
// repeated walks of the store, then the y spread and the box edges.
// ----------------------------------------------------------------------------
module losb_back #(
    parameter int MAX_POINTS = 1024,
    parameter int X_BIAS     = -41
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  losb_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  losb_pkg::t_pt        i_pt,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic signed [19:0]   o_near_x,
    output logic signed [19:0]   o_far_x,
    output logic signed [19:0]   o_low_y,
    output logic signed [19:0]   o_high_y,
    output logic                 o_overflow
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = IW + 1;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SEL, S_YSCAN, S_BOX1, S_BOX2, S_OUT} t_state;

    logic [39:0]         r_mem [MAX_POINTS];
    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic                r_ovf;
    logic [CW-1:0]       r_addr;
    logic                r_rd_vld;
    logic [IW-1:0]       r_rd_idx;
    logic [39:0]         r_rd_dat;
    logic [9:0]          r_pass;
    logic                r_have;
    logic signed [19:0]  r_best_x;
    logic [IW-1:0]       r_best_i;
    logic                r_prev_vld;
    logic signed [19:0]  r_prev_x;
    logic [IW-1:0]       r_prev_i;
    logic signed [19:0]  r_min_y;
    logic signed [19:0]  r_max_y;
    logic signed [23:0]  r_s;
    logic signed [23:0]  r_c;
    logic [1:0]          r_status;
    logic signed [19:0]  r_near_x;
    logic signed [19:0]  r_far_x;
    logic signed [19:0]  r_low_y;
    logic signed [19:0]  r_high_y;

    logic                issue;
    logic                walk_end;
    logic                wr_en;
    logic signed [19:0]  dx;
    logic signed [19:0]  dy;
    logic                gt_prev;
    logic                lt_best;
    logic signed [23:0]  spread;
    logic signed [23:0]  offs;

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_status   = r_status;
    assign o_near_x   = r_near_x;
    assign o_far_x    = r_far_x;
    assign o_low_y    = r_low_y;
    assign o_high_y   = r_high_y;
    assign o_overflow = r_ovf;

    assign issue    = ((r_state == S_SEL) || (r_state == S_YSCAN)) && (r_addr < r_count);
    assign walk_end = (r_addr == r_count) && !r_rd_vld;
    assign wr_en    = (r_state == S_IDLE) && i_valid && i_pt.crit &&
                      (r_count < CW'(MAX_POINTS));
    assign dx       = r_rd_dat[39:20];
    assign dy       = r_rd_dat[19:0];
    assign offs     = 24'(X_BIAS);

    // key order: x, then store index
    always_comb begin
        gt_prev = !r_prev_vld || (dx > r_prev_x) || ((dx == r_prev_x) && (r_rd_idx > r_prev_i));
        lt_best = !r_have || (dx < r_best_x) || ((dx == r_best_x) && (r_rd_idx < r_best_i));
        spread  = 24'(r_max_y) - 24'(r_min_y);
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IW-1:0]] <= {i_pt.x, i_pt.y};
        end
        r_rd_dat <= r_mem[r_addr[IW-1:0]];
        r_rd_idx <= r_addr[IW-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (issue) begin
                r_addr <= r_addr + CW'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_pt.crit) begin
                            if (r_count < CW'(MAX_POINTS)) begin
                                r_count <= r_count + CW'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                        if (i_pt.last) begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_near_x   <= '0;
                    r_far_x    <= '0;
                    r_low_y    <= '0;
                    r_high_y   <= '0;
                    r_addr     <= '0;
                    r_pass     <= '0;
                    r_have     <= 1'b0;
                    r_prev_vld <= 1'b0;
                    if (16'(r_count) < 16'(i_cfg.min_pts)) begin
                        r_status <= losb_pkg::ST_FEW;
                        r_state  <= S_OUT;
                    end else if (16'(i_cfg.drop) >= 16'(r_count)) begin
                        r_status <= losb_pkg::ST_DROP_BIG;
                        r_state  <= S_OUT;
                    end else begin
                        r_status <= losb_pkg::ST_OK;
                        r_state  <= S_SEL;
                    end
                end
                S_SEL: begin
                    // find the smallest key above the previous threshold
                    if (r_rd_vld && gt_prev && lt_best) begin
                        r_have   <= 1'b1;
                        r_best_x <= dx;
                        r_best_i <= r_rd_idx;
                    end
                    if (walk_end) begin
                        r_prev_vld <= 1'b1;
                        r_prev_x   <= r_best_x;
                        r_prev_i   <= r_best_i;
                        r_have     <= 1'b0;
                        r_addr     <= '0;
                        if (r_pass == i_cfg.drop) begin
                            r_min_y <= losb_pkg::LEN_MAX;
                            r_max_y <= losb_pkg::LEN_MIN;
                            r_state <= S_YSCAN;
                        end else begin
                            r_pass <= r_pass + 10'd1;
                        end
                    end
                end
                S_YSCAN: begin
                    // keys at or above the threshold remain
                    if (r_rd_vld && !((dx < r_prev_x) ||
                                      ((dx == r_prev_x) && (r_rd_idx < r_prev_i)))) begin
                        if (dy < r_min_y) r_min_y <= dy;
                        if (dy > r_max_y) r_max_y <= dy;
                    end
                    if (walk_end) begin
                        r_state <= S_BOX1;
                    end
                end
                S_BOX1: begin
                    r_s     <= (spread < $signed({5'd0, i_cfg.min_size})) ?
                               $signed({5'd0, i_cfg.min_size}) : spread;
                    r_c     <= 24'(r_min_y) + 24'(r_max_y);
                    r_state <= S_BOX2;
                end
                S_BOX2: begin
                    r_near_x <= losb_pkg::sat20(24'(r_prev_x) + offs);
                    r_far_x  <= losb_pkg::sat20(24'(r_prev_x) + r_s + offs);
                    r_low_y  <= losb_pkg::sat20((r_c - r_s) >>> 1);
                    r_high_y <= losb_pkg::sat20((r_c + r_s + 24'sd1) >>> 1);
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for laser_scan_obstacle_box. A behavioral model of the
// CORDIC front and of the box selection predicts one box per scan. Each box
// that leaves the block is compared field by field in order. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [1:0]         status;
        logic signed [19:0] near_x;
        logic signed [19:0] far_x;
        logic signed [19:0] low_y;
        logic signed [19:0] high_y;
        logic               ovf;
    } t_box;

    localparam longint ATAN_LUT [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679840, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };
    localparam int     STORE_DEPTH = 1024;
    localparam longint X_OFFSET    = -41;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [3:0]   i_cfg_index;
    logic [19:0]  i_cfg_data;

    // register shadow
    longint win_lo, win_hi, band_lo, band_hi, safe_dist, min_pts, drop_cnt, min_edge;

    // scan state of the model
    longint pt_x[$];
    longint pt_y[$];
    bit     pt_ovf;

    t_box   box_expect_q[$];
    int     err_cnt;
    bit     no_gaps;

    laser_scan_obstacle_box i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint sat_len(input longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // rotate range by beam angle into x,y
    task automatic polar_to_xy(input longint r, input longint ang,
                               output longint px, output longint py);
        longint x, y, z, dx, dy;
        bit     flip;
        flip = 1'b0;
        if (ang > 16384) begin
            ang -= 32768;
            flip = 1'b1;
        end else if (ang < -16384) begin
            ang += 32768;
            flip = 1'b1;
        end
        x = r * 19898;
        y = 0;
        z = ang * 65536;
        for (int i = 0; i < 16; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0) begin
                x -= dy; y += dx; z -= ATAN_LUT[i];
            end else begin
                x += dy; y -= dx; z += ATAN_LUT[i];
            end
        end
        x = (x + 16384) >>> 15;
        y = (y + 16384) >>> 15;
        if (flip) begin
            x = -x; y = -y;
        end
        px = sat_len(x);
        py = sat_len(y);
    endtask

    // close the scan: discard nearest points and size the box
    task automatic scan_finish();
        t_box   b;
        longint n, rank, mn_x, mn_y, mx_y, s, c;
        bit     have;
        n = pt_x.size();
        b.status = losb_pkg::ST_OK;
        b.near_x = '0;
        b.far_x  = '0;
        b.low_y  = '0;
        b.high_y = '0;
        b.ovf    = pt_ovf;
        mn_x = 0; mn_y = 524287; mx_y = -524288; have = 0;
        if (n < min_pts) begin
            b.status = losb_pkg::ST_FEW;
        end else if (drop_cnt >= n) begin
            b.status = losb_pkg::ST_DROP_BIG;
        end else begin
            for (int i = 0; i < n; i++) begin
                rank = 0;
                for (int j = 0; j < n; j++)
                    if (pt_x[j] < pt_x[i] || (pt_x[j] == pt_x[i] && j < i)) rank++;
                if (rank >= drop_cnt) begin
                    if (!have || pt_x[i] < mn_x) mn_x = pt_x[i];
                    have = 1;
                    if (pt_y[i] < mn_y) mn_y = pt_y[i];
                    if (pt_y[i] > mx_y) mx_y = pt_y[i];
                end
            end
            s = mx_y - mn_y;
            if (s < min_edge) s = min_edge;
            c = mn_y + mx_y;
            b.near_x = 20'(sat_len(mn_x + X_OFFSET));
            b.far_x  = 20'(sat_len(mn_x + s + X_OFFSET));
            b.low_y  = 20'(sat_len((c - s) >>> 1));
            b.high_y = 20'(sat_len(-((-(c + s)) >>> 1)));
        end
        box_expect_q = {box_expect_q, b};
        pt_x.delete();
        pt_y.delete();
        pt_ovf = 0;
    endtask

    task automatic predict_sample(input longint r, input longint ang, input bit last);
        longint x, y;
        if (ang >= win_lo && ang <= win_hi) begin
            polar_to_xy(r, ang, x, y);
            if (!(x < 41 && x > -41 && y < 41 && y > -41) &&
                y >= band_lo && y <= band_hi && x < safe_dist) begin
                if (pt_x.size() < STORE_DEPTH) begin
                    pt_x = {pt_x, x};
                    pt_y = {pt_y, y};
                end else begin
                    pt_ovf = 1;
                end
            end
        end
        if (last) scan_finish();
    endtask

    // send one sample and hold it until accepted
    task automatic send_sample(input logic [18:0] r, input logic signed [15:0] ang,
                               input bit last);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, ang, r};
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        predict_sample(longint'(r), longint'(ang), last);
    endtask

    // wait until every box is out and the block is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (box_expect_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input longint val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[19:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            losb_pkg::CFG_WIN_LO:   win_lo    = longint'($signed(val[15:0]));
            losb_pkg::CFG_WIN_HI:   win_hi    = longint'($signed(val[15:0]));
            losb_pkg::CFG_BAND_LO:  band_lo   = longint'($signed(val[19:0]));
            losb_pkg::CFG_BAND_HI:  band_hi   = longint'($signed(val[19:0]));
            losb_pkg::CFG_SAFE:     safe_dist = val & 64'h7FFFF;
            losb_pkg::CFG_MIN_PTS:  min_pts   = val & 64'h7FF;
            losb_pkg::CFG_DROP:     drop_cnt  = val & 64'h3FF;
            default:                min_edge  = val & 64'h7FFFF;
        endcase
    endtask

    task automatic write_all(input longint wl, wh, bl, bh, sd, mp, dc, ms);
        write_reg(losb_pkg::CFG_WIN_LO, wl);
        write_reg(losb_pkg::CFG_WIN_HI, wh);
        write_reg(losb_pkg::CFG_BAND_LO, bl);
        write_reg(losb_pkg::CFG_BAND_HI, bh);
        write_reg(losb_pkg::CFG_SAFE, sd);
        write_reg(losb_pkg::CFG_MIN_PTS, mp);
        write_reg(losb_pkg::CFG_DROP, dc);
        write_reg(losb_pkg::CFG_MIN_SIZE, ms);
    endtask

    // field extremes at reset settings, then with everything accepted
    task automatic test_extremes();
        send_sample(19'd0, 16'sd0, 1'b0);
        send_sample(19'h7FFFF, 16'sd0, 1'b0);
        send_sample(19'd1000, -16'sd13559, 1'b0);
        send_sample(19'd1000, 16'sd13559, 1'b1);
        drain();
        write_all(-32768, 32767, -524288, 524287, 524287, 1, 0, 0);
        send_sample(19'd0, 16'sd0, 1'b0);
        send_sample(19'h7FFFF, -16'sd32768, 1'b0);
        send_sample(19'h7FFFF, 16'sd32767, 1'b0);
        send_sample(19'd3000, 16'sd16384, 1'b0);
        send_sample(19'd3000, -16'sd16384, 1'b0);
        send_sample(19'd3000, 16'sd16385, 1'b0);
        send_sample(19'd3000, -16'sd16385, 1'b0);
        send_sample(19'd30, 16'sd100, 1'b0);
        send_sample(19'h55555, 16'sh2AAA, 1'b0);
        send_sample(19'h2AAAA, -16'sh2AAB, 1'b1);
        drain();
        // edge sizes saturate
        write_reg(losb_pkg::CFG_MIN_SIZE, 524287);
        send_sample(19'h7FFFF, 16'sd8000, 1'b0);
        send_sample(19'h7FFFF, -16'sd8000, 1'b1);
        drain();
    endtask

    // too few points, drop count too big, empty window, zero min points
    task automatic test_status();
        write_all(-32768, 32767, -524288, 524287, 524287, 1, 5, 1229);
        repeat (3) send_sample(19'd2000, 16'sd500, 1'b0);
        send_sample(19'd2000, 16'sd500, 1'b1);
        drain();
        write_reg(losb_pkg::CFG_DROP, 1023);
        send_sample(19'd2000, 16'sd500, 1'b1);
        drain();
        write_all(100, -100, -1024, 1024, 1638, 1024, 0, 1229);
        send_sample(19'd1000, 16'sd0, 1'b0);
        send_sample(19'd1000, 16'sd0, 1'b1);
        drain();
        write_reg(losb_pkg::CFG_MIN_PTS, 0);
        send_sample(19'd1000, 16'sd0, 1'b1);
        drain();
    endtask

    // fill the point store past its depth
    task automatic test_overflow();
        write_all(-32768, 32767, -524288, 524287, 524287, 1, 2, 100);
        no_gaps = 1;
        for (int i = 0; i < STORE_DEPTH + 8; i++)
            send_sample(19'($urandom_range(100, 4000)), 16'($urandom_range(0, 4000) - 2000),
                        i == STORE_DEPTH + 7);
        send_sample(19'd1500, 16'sd0, 1'b1);
        no_gaps = 0;
        drain();
    endtask

    // random settings, scans of random length and content
    task automatic test_random();
        int     sent, len, wl, wh;
        longint bl, bh, sd, mp, dc, ms;
        sent = 0;
        while (sent < 450) begin
            wl = $urandom_range(0, 3) == 0 ? -32768 : -$urandom_range(0, 20000);
            wh = $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(0, 20000);
            bl = $urandom_range(0, 4) == 0 ? -524288 : -longint'($urandom_range(0, 3000));
            bh = $urandom_range(0, 4) == 0 ? 524287 : longint'($urandom_range(0, 3000));
            sd = $urandom_range(0, 4) == 0 ? 524287 : longint'($urandom_range(0, 5000));
            mp = $urandom_range(0, 9) == 0 ? 1024 : longint'($urandom_range(0, 8));
            dc = $urandom_range(0, 9) == 0 ? 1023 : longint'($urandom_range(0, 6));
            ms = $urandom_range(0, 6) == 0 ? 524287 : longint'($urandom_range(0, 3000));
            write_all(wl, wh, bl, bh, sd, mp, dc, ms);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (3) begin
                len = $urandom_range(1, 30);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_sample(19'($urandom), 16'($urandom), i == len - 1);
                    else
                        send_sample(19'($urandom_range(0, 6000)),
                                    16'($urandom_range(0, 30000) - 15000), i == len - 1);
                end
                sent += len;
            end
            drain();
        end
        no_gaps = 0;
    endtask

    // result stall pattern: long ready stretches, short and long stalls
    int rdy_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b1;
            rdy_left <= 0;
        end else if (rdy_left > 0) begin
            rdy_left <= rdy_left - 1;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            rdy_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
            rdy_left <= $urandom_range(1, 80);
        end
    end

    // compare each box with the oldest prediction
    always @(posedge i_clk) begin
        t_box b;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (box_expect_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected box: tdata=%h tuser=%h", m_tdata, m_tuser);
            end else begin
                b = box_expect_q.pop_front();
                if (m_tuser[1:0] !== b.status || m_tuser[2] !== b.ovf ||
                    m_tdata[19:0] !== b.near_x || m_tdata[39:20] !== b.far_x ||
                    m_tdata[59:40] !== b.low_y || m_tdata[79:60] !== b.high_y) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"box mismatch: exp st=%0d ov=%0d nx=%0d fx=%0d ly=%0d hy=%0d,",
                                  " got st=%0d ov=%0d nx=%0d fx=%0d ly=%0d hy=%0d"},
                                 b.status, b.ovf, b.near_x, b.far_x, b.low_y, b.high_y,
                                 m_tuser[1:0], m_tuser[2], $signed(m_tdata[19:0]),
                                 $signed(m_tdata[39:20]), $signed(m_tdata[59:40]),
                                 $signed(m_tdata[79:60]));
                end
            end
        end
    end

    initial begin
        #8000000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        err_cnt     = 0;
        no_gaps     = 0;
        pt_ovf      = 0;
        win_lo = -13559; win_hi = 13559; band_lo = -1024; band_hi = 1024;
        safe_dist = 1638; min_pts = 15; drop_cnt = 5; min_edge = 1229;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_status();
        test_overflow();
        test_random();
        drain();
        if (err_cnt == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> laser_scan_obstacle_box.f
src/losb_pkg.sv
src/losb_front.sv
src/losb_queue.sv
src/losb_back.sv
src/laser_scan_obstacle_box.sv
test/testbench.sv
